### sv/lrc_pkg.sv
`timescale 1ns / 1ps

package lrc_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KindStart = 2'd0,
    KindPixel = 2'd1,
    KindRead  = 2'd2
  } lrc_kind_e;

  // Geometry and coding constants
  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned ColumnRows = 8;
  localparam int unsigned WidthCap   = (MaxWidth < 4096) ? MaxWidth : 4096;

  localparam logic [7:0]  NoLabel     = 8'd255;
  localparam logic [12:0] YOffset     = 13'd4;
  localparam logic [23:0] LenMax      = 24'hFFFFFF;
  localparam logic [12:0] WidthReset  = 13'd1024;
  localparam int unsigned EntryBits   = 24 + 12 + 13;

  // Input word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] label_row0;
    logic [7:0] label_row1;
    logic [7:0] label_row2;
    logic [7:0] label_row3;
    logic [7:0] label_row4;
    logic [7:0] label_row5;
    logic [7:0] label_row6;
    logic [7:0] label_row7;
    logic [7:0] query_label;
  } lrc_in_t;

  // Result word
  typedef struct packed {
    logic        found;
    logic [11:0] center_x;
    logic [12:0] center_y;
    logic [7:0]  echo_label;
  } lrc_out_t;

  // One record of the per-label table
  typedef struct packed {
    logic [23:0] length;
    logic [11:0] x;
    logic [12:0] y;
  } lrc_entry_t;

endpackage

### sv/lrc_best_mem.sv
`timescale 1ns / 1ps

// Per-label record table: one write port, two registered read ports.
// Port A reads every cycle, port B only when enabled.
module lrc_best_mem (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [7:0]          waddr_i,
  input  lrc_pkg::lrc_entry_t wdata_i,
  input  logic [7:0]          raddr_a_i,
  output lrc_pkg::lrc_entry_t rdata_a_o,
  input  logic                re_b_i,
  input  logic [7:0]          raddr_b_i,
  output lrc_pkg::lrc_entry_t rdata_b_o
);

  lrc_pkg::lrc_entry_t mem [256];
  lrc_pkg::lrc_entry_t rdata_a_q;
  lrc_pkg::lrc_entry_t rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read ports, read-before-write
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### sv/label_longest_run_center_core.sv
`timescale 1ns / 1ps

// Longest horizontal run per label, with the run's center.
// Input channel (in_valid_i / in_stall_o / in_word_i) carries start, pixel
// and read words. Pixel words are streamed in raster order; each holds a
// column of eight labels that counts as a label only when all agree.
// Output channel (out_valid_o / out_stall_i / out_word_o) returns one word
// per read word: found flag, recorded center and the queried label.
// Throughput: one input word per cycle while in_stall_o is low. Start and pixel
// words finish at their accept edge; a read word's result passes the table
// read register, then the output register, before out_valid_o rises.
// The record table read port A tracks the open run's label each cycle so
// the compare-and-write of a finished run fits in the accept cycle.
// Reset: run state, position and all found flags clear, image_width goes
// to 1024; table contents stay undefined until a run is recorded.
// When the receiver stalls, the output word holds, one more read result
// can wait in the read stage, and in_stall_o rises once both are full.
// Config: APB register 0 (paddr[2] low, so addresses 0 to 3) is image_width, 13 bits.
module label_longest_run_center_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lrc_pkg::lrc_in_t in_word_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lrc_pkg::lrc_out_t out_word_o,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // State
  logic [12:0]  width_q, width_d;
  logic [7:0]   prev_q, prev_d;
  logic [11:0]  start_x_q, start_x_d;
  logic [11:0]  end_x_q, end_x_d;
  logic [23:0]  run_len_q, run_len_d;
  logic [11:0]  pos_x_q, pos_x_d;
  logic [11:0]  pos_y_q, pos_y_d;
  logic [255:0] seen_q, seen_d;

  // Read stage and output register
  logic              s1_v_q, s1_v_d;
  logic              s1_found_q;
  logic [7:0]        s1_label_q;
  logic              out_v_q, out_v_d;
  lrc_pkg::lrc_out_t out_q;

  logic                in_acc;
  logic                s1_move;
  logic                is_read;
  logic [7:0]          col;
  logic [12:0]         eff_w;
  logic [12:0]         x_sum;
  logic [12:0]         x_next;
  logic [11:0]         y_next;
  logic                mem_we;
  lrc_pkg::lrc_entry_t mem_wdata;
  lrc_pkg::lrc_entry_t rd_a;
  lrc_pkg::lrc_entry_t rd_b;

  // Handshake
  assign in_stall_o = s1_v_q && out_v_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_read    = in_acc && (in_word_i.kind == lrc_pkg::KindRead);
  assign s1_move    = s1_v_q && (!out_v_q || !out_stall_i);

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {19'd0, width_q} : 32'd0;

  always_comb begin
    width_d = width_q;
    if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      width_d = pwdata[12:0];
    end
  end

  // Column label: all rows must agree
  always_comb begin
    logic [7:0] rows [8];
    rows[0] = in_word_i.label_row0;
    rows[1] = in_word_i.label_row1;
    rows[2] = in_word_i.label_row2;
    rows[3] = in_word_i.label_row3;
    rows[4] = in_word_i.label_row4;
    rows[5] = in_word_i.label_row5;
    rows[6] = in_word_i.label_row6;
    rows[7] = in_word_i.label_row7;
    col = rows[0];
    for (int r = 1; r < 8; r++) begin
      if ((r < lrc_pkg::ColumnRows) && (rows[r] != rows[0])) begin
        col = lrc_pkg::NoLabel;
      end
    end
  end

  // Effective row width
  always_comb begin
    eff_w = width_q;
    if (eff_w == 13'd0) begin
      eff_w = 13'd1;
    end
    if (32'(eff_w) > lrc_pkg::WidthCap) begin
      eff_w = 13'(lrc_pkg::WidthCap);
    end
  end

  assign x_sum  = {1'b0, start_x_q} + {1'b0, end_x_q};
  assign x_next = {1'b0, pos_x_q} + 13'd1;
  assign y_next = pos_y_q + 12'd1;

  // Commit of a finished run
  assign mem_wdata.length = run_len_q;
  assign mem_wdata.x      = x_sum[12:1];
  assign mem_wdata.y      = {1'b0, pos_y_q} + lrc_pkg::YOffset;

  // Run tracking and position stepping
  always_comb begin
    prev_d    = prev_q;
    start_x_d = start_x_q;
    end_x_d   = end_x_q;
    run_len_d = run_len_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    seen_d    = seen_q;
    mem_we    = 1'b0;
    if (in_acc) begin
      case (in_word_i.kind)
        lrc_pkg::KindStart: begin
          prev_d    = lrc_pkg::NoLabel;
          start_x_d = '0;
          end_x_d   = '0;
          run_len_d = '0;
          pos_x_d   = '0;
          pos_y_d   = '0;
          seen_d    = '0;
        end
        lrc_pkg::KindPixel: begin
          if ((col == prev_q) && (col != lrc_pkg::NoLabel)) begin
            if (run_len_q != lrc_pkg::LenMax) begin
              run_len_d = run_len_q + 24'd1;
            end
            end_x_d = pos_x_q;
          end else begin
            if (prev_q != lrc_pkg::NoLabel) begin
              if (!seen_q[prev_q] || (rd_a.length < run_len_q)) begin
                mem_we         = 1'b1;
                seen_d[prev_q] = 1'b1;
              end
            end
            prev_d    = col;
            start_x_d = pos_x_q;
            end_x_d   = pos_x_q;
            run_len_d = 24'd1;
          end
          if (x_next >= eff_w) begin
            pos_x_d = '0;
            pos_y_d = (32'(y_next) >= lrc_pkg::MaxHeight) ? 12'd0 : y_next;
          end else begin
            pos_x_d = x_next[11:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Record table
  lrc_best_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (prev_q),
    .wdata_i   (mem_wdata),
    .raddr_a_i (prev_d),
    .rdata_a_o (rd_a),
    .re_b_i    (is_read),
    .raddr_b_i (in_word_i.query_label),
    .rdata_b_o (rd_b)
  );

  // Pipeline valids
  always_comb begin
    s1_v_d = is_read || (s1_v_q && !s1_move);
    out_v_d = s1_move || (out_v_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= lrc_pkg::WidthReset;
      prev_q    <= lrc_pkg::NoLabel;
      start_x_q <= '0;
      end_x_q   <= '0;
      run_len_q <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      seen_q    <= '0;
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      width_q   <= width_d;
      prev_q    <= prev_d;
      start_x_q <= start_x_d;
      end_x_q   <= end_x_d;
      run_len_q <= run_len_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      seen_q    <= seen_d;
      s1_v_q    <= s1_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (is_read) begin
      s1_found_q <= seen_q[in_word_i.query_label];
      s1_label_q <= in_word_i.query_label;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.found      <= s1_found_q;
      out_q.center_x   <= s1_found_q ? rd_b.x : 12'd0;
      out_q.center_y   <= s1_found_q ? rd_b.y : 13'd0;
      out_q.echo_label <= s1_label_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // Assertions
  a_no_commit_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (prev_q != lrc_pkg::NoLabel))
    else $error("commit to the no-label entry");

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (prev_d != prev_q))
    else $error("table write collides with run label read");

  a_read_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read |=> s1_v_q)
    else $error("read word lost before read stage");

  a_read_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && out_stall_i) |=> (s1_v_q && out_v_q))
    else $error("stalled read result dropped");

endmodule
